// File: hw/rtl/accel_activity_inactivity_detector_unit_assert.svh
// Assertion macros for the activity/inactivity detector.
// Included by the RTL files that carry concurrent checks; needs no package.
`ifndef ACCEL_ACTIVITY_INACTIVITY_DETECTOR_UNIT_ASSERT_SVH
`define ACCEL_ACTIVITY_INACTIVITY_DETECTOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define AAID_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aaid assertion failed");

// next-cycle implication, disabled while reset is asserted
`define AAID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aaid assertion failed");

`endif

// File: hw/rtl/aaid_pkg.sv
// Shared types and constants for the activity/inactivity detector.
// No dependencies; used by the interfaces and every RTL module.
`default_nettype none

package aaid_pkg;

    localparam int NUM_AXES   = 3;
    localparam int SAMPLE_W   = 12;
    localparam int DELTA_W    = 12;
    localparam int THR_W      = 11;
    localparam int ACT_TIME_W = 8;
    localparam int INACT_TIME_W = 16;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_ACT_THRESHOLD   = 2'd0;
    localparam logic [1:0] REG_INACT_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_ACT_TIME        = 2'd2;
    localparam logic [1:0] REG_INACT_TIME      = 2'd3;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [DELTA_W-1:0]         t_delta;

    typedef struct packed {
        logic [THR_W-1:0]        act_threshold;
        logic [THR_W-1:0]        inact_threshold;
        logic [ACT_TIME_W-1:0]   act_time;
        logic [INACT_TIME_W-1:0] inact_time;
    } t_cfg;

    typedef struct packed {
        logic act_above;
        logic inact_below;
    } t_flags;

endpackage

`default_nettype wire

// File: hw/rtl/aaid_if.sv
// Valid/ready channel interfaces: sample input and awake-flag result.
// Depends on aaid_pkg.
`default_nettype none

interface aaid_in_if;
    import aaid_pkg::*;

    logic    valid;
    logic    ready;
    t_sample accel_x;
    t_sample accel_y;
    t_sample accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    output ready);
endinterface

interface aaid_out_if;
    logic valid;
    logic ready;
    logic is_awake;

    modport source (output valid, output is_awake, input ready);
    modport sink   (input valid, input is_awake, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/aaid_lane.sv
// One axis lane: absolute distance of the sample from both references.
// Depends on aaid_pkg.
`default_nettype none

module aaid_lane (
    input  aaid_pkg::t_sample i_sample,
    input  aaid_pkg::t_sample i_act_ref,
    input  aaid_pkg::t_sample i_inact_ref,
    output aaid_pkg::t_delta  o_act_delta,
    output aaid_pkg::t_delta  o_inact_delta
);
    import aaid_pkg::*;

    logic signed [SAMPLE_W:0] act_diff;
    logic signed [SAMPLE_W:0] inact_diff;
    logic signed [SAMPLE_W:0] act_abs;
    logic signed [SAMPLE_W:0] inact_abs;

    assign act_diff   = {i_sample[SAMPLE_W-1], i_sample} - {i_act_ref[SAMPLE_W-1], i_act_ref};
    assign inact_diff = {i_sample[SAMPLE_W-1], i_sample}
                      - {i_inact_ref[SAMPLE_W-1], i_inact_ref};

    assign act_abs   = act_diff[SAMPLE_W] ? -act_diff : act_diff;
    assign inact_abs = inact_diff[SAMPLE_W] ? -inact_diff : inact_diff;

    // |diff| <= 4095, fits the delta width
    assign o_act_delta   = act_abs[DELTA_W-1:0];
    assign o_inact_delta = inact_abs[DELTA_W-1:0];

endmodule

`default_nettype wire

// File: hw/rtl/aaid_merge.sv
// Merge stage: maximum delta over the axis lanes and threshold compares.
// Depends on aaid_pkg.
`default_nettype none

module aaid_merge (
    input  aaid_pkg::t_delta i_act_delta   [aaid_pkg::NUM_AXES],
    input  aaid_pkg::t_delta i_inact_delta [aaid_pkg::NUM_AXES],
    input  aaid_pkg::t_cfg   i_cfg,
    output aaid_pkg::t_flags o_flags
);
    import aaid_pkg::*;

    t_delta max_act;
    t_delta max_inact;

    always_comb begin
        max_act   = '0;
        max_inact = '0;
        for (int i = 0; i < NUM_AXES; i++) begin
            if (i_act_delta[i] > max_act) begin
                max_act = i_act_delta[i];
            end
            if (i_inact_delta[i] > max_inact) begin
                max_inact = i_inact_delta[i];
            end
        end
    end

    assign o_flags.act_above   = max_act > {{(DELTA_W-THR_W){1'b0}}, i_cfg.act_threshold};
    assign o_flags.inact_below = max_inact < {{(DELTA_W-THR_W){1'b0}}, i_cfg.inact_threshold};

endmodule

`default_nettype wire

// File: hw/rtl/aaid_cfg.sv
// APB-style configuration registers: thresholds and time counts.
// Depends on aaid_pkg.
`default_nettype none

module aaid_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [aaid_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [aaid_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [aaid_pkg::APB_DATA_W-1:0] prdata,
    output logic                               pready,
    output aaid_pkg::t_cfg                     o_cfg
);
    import aaid_pkg::*;

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[APB_ADDR_W-1:2];

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                REG_ACT_THRESHOLD:   n_cfg.act_threshold   = pwdata[THR_W-1:0];
                REG_INACT_THRESHOLD: n_cfg.inact_threshold = pwdata[THR_W-1:0];
                REG_ACT_TIME:        n_cfg.act_time        = pwdata[ACT_TIME_W-1:0];
                REG_INACT_TIME:      n_cfg.inact_time      = pwdata[INACT_TIME_W-1:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ACT_THRESHOLD:   prdata = APB_DATA_W'(r_cfg.act_threshold);
            REG_INACT_THRESHOLD: prdata = APB_DATA_W'(r_cfg.inact_threshold);
            REG_ACT_TIME:        prdata = APB_DATA_W'(r_cfg.act_time);
            REG_INACT_TIME:      prdata = APB_DATA_W'(r_cfg.inact_time);
            default:             prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: hw/rtl/accel_activity_inactivity_detector_unit.sv
// Accelerometer activity/inactivity detector, top level.
// Depends on aaid_pkg, aaid_if, aaid_lane, aaid_merge, aaid_cfg and the assert header.
//
// Usage:
//   i_sample carries one x/y/z sample per transfer (12-bit two's complement).
//   o_result carries one is_awake flag per accepted sample, in order.
//   Configuration is written over the APB-style port (4 registers at 0x0..0xC)
//   while no sample is in flight.
// Timing:
//   Three axis lanes form the distances to both references in parallel, a merge
//   stage takes the maximum and compares against the thresholds, and the state
//   update happens at the accepting edge, which also registers the result into the
//   output register, or the skid register while a result waits. One sample per cycle
//   is sustained while i_sample.ready is high; the state registers close the loop.
// Stall:
//   An output register plus a one-entry skid register hold results. A sample is
//   still taken while a result waits; i_sample.ready drops only when both hold data.
// Reset:
//   Synchronous, active low. Clears registers, counters, references, the awake
//   flag and the valid bits of both output stages.
`default_nettype none

`include "accel_activity_inactivity_detector_unit_assert.svh"

module accel_activity_inactivity_detector_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    aaid_in_if.sink                            i_sample,
    aaid_out_if.source                         o_result,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [aaid_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [aaid_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [aaid_pkg::APB_DATA_W-1:0] prdata,
    output logic                               pready
);
    import aaid_pkg::*;

    t_cfg    cfg;
    t_flags  flags;
    t_sample smp       [NUM_AXES];
    t_delta  act_delta [NUM_AXES];
    t_delta  inact_delta [NUM_AXES];

    logic                    r_awake;
    logic                    n_awake;
    logic [ACT_TIME_W-1:0]   r_wake_count;
    logic [ACT_TIME_W-1:0]   n_wake_count;
    logic [INACT_TIME_W-1:0] r_sleep_count;
    logic [INACT_TIME_W-1:0] n_sleep_count;
    logic                    r_rebase;
    logic                    n_rebase;
    t_sample                 r_act_ref   [NUM_AXES];
    t_sample                 r_inact_ref [NUM_AXES];
    logic                    upd_act_ref;
    logic                    upd_inact_ref;
    logic [ACT_TIME_W-1:0]   wake_inc;
    logic [INACT_TIME_W-1:0] sleep_inc;

    logic r_out_valid;
    logic r_out_awake;
    logic r_skid_valid;
    logic r_skid_awake;
    logic in_xfer;
    logic out_xfer;

    aaid_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign smp[0] = i_sample.accel_x;
    assign smp[1] = i_sample.accel_y;
    assign smp[2] = i_sample.accel_z;

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
        aaid_lane u_lane (
            .i_sample      (smp[g]),
            .i_act_ref     (r_act_ref[g]),
            .i_inact_ref   (r_inact_ref[g]),
            .o_act_delta   (act_delta[g]),
            .o_inact_delta (inact_delta[g])
        );
    end

    aaid_merge u_merge (
        .i_act_delta   (act_delta),
        .i_inact_delta (inact_delta),
        .i_cfg         (cfg),
        .o_flags       (flags)
    );

    assign in_xfer  = i_sample.valid && i_sample.ready;
    assign out_xfer = r_out_valid && o_result.ready;

    assign wake_inc  = (r_wake_count == '1) ? r_wake_count : r_wake_count + 1'b1;
    assign sleep_inc = (r_sleep_count == '1) ? r_sleep_count : r_sleep_count + 1'b1;

    always_comb begin
        n_awake       = r_awake;
        n_wake_count  = r_wake_count;
        n_sleep_count = r_sleep_count;
        n_rebase      = r_rebase;
        upd_act_ref   = 1'b0;
        upd_inact_ref = 1'b0;
        if (r_awake) begin
            if (flags.inact_below) begin
                if (sleep_inc >= cfg.inact_time) begin
                    n_awake       = 1'b0;
                    n_rebase      = 1'b1;
                    n_sleep_count = '0;
                end else begin
                    n_sleep_count = sleep_inc;
                end
            end else begin
                n_sleep_count = '0;
                upd_inact_ref = 1'b1;
            end
        end else begin
            if (flags.act_above) begin
                if (wake_inc >= cfg.act_time) begin
                    n_awake      = 1'b1;
                    n_wake_count = '0;
                end else begin
                    n_wake_count = wake_inc;
                end
            end else begin
                n_wake_count = '0;
            end
            upd_inact_ref = !flags.inact_below;
            if (r_rebase) begin
                upd_act_ref = 1'b1;
                n_rebase    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awake       <= 1'b0;
            r_wake_count  <= '0;
            r_sleep_count <= '0;
            r_rebase      <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++) begin
                r_act_ref[i]   <= '0;
                r_inact_ref[i] <= '0;
            end
        end else if (in_xfer) begin
            r_awake       <= n_awake;
            r_wake_count  <= n_wake_count;
            r_sleep_count <= n_sleep_count;
            r_rebase      <= n_rebase;
            for (int i = 0; i < NUM_AXES; i++) begin
                if (upd_act_ref) begin
                    r_act_ref[i] <= smp[i];
                end
                if (upd_inact_ref) begin
                    r_inact_ref[i] <= smp[i];
                end
            end
        end
    end

    // output register with one-entry skid
    assign i_sample.ready  = !r_skid_valid;
    assign o_result.valid  = r_out_valid;
    assign o_result.is_awake = r_out_awake;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_xfer) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_xfer;
            end
        end else if (in_xfer) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_xfer) begin
            if (r_skid_valid) begin
                r_out_awake <= r_skid_awake;
            end else if (in_xfer) begin
                r_out_awake <= n_awake;
            end
        end else if (in_xfer) begin
            if (r_out_valid) begin
                r_skid_awake <= n_awake;
            end else begin
                r_out_awake <= n_awake;
            end
        end
    end

    `AAID_ASSERT_NOW(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `AAID_ASSERT_NEXT(a_stall_fills_skid, i_clk, i_rst_n,
        in_xfer && r_out_valid && !o_result.ready, r_skid_valid)
    `AAID_ASSERT_NOW(a_rebase_only_asleep, i_clk, i_rst_n, r_rebase, !r_awake)
    `AAID_ASSERT_NOW(a_awake_no_wake_count, i_clk, i_rst_n, r_awake, r_wake_count == '0)
    `AAID_ASSERT_NEXT(a_result_follows_state, i_clk, i_rst_n,
        in_xfer && !r_out_valid, r_out_valid && (r_out_awake == r_awake))

endmodule

`default_nettype wire
